// ===== rtl/telemetry_frame_receiver_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Telemetry frame receiver assertion macros
// Shared concurrent assertion forms, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef TELEMETRY_FRAME_RECEIVER_UNIT_MACROS_SVH
`define TELEMETRY_FRAME_RECEIVER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define TFR_ASSERT_IMPLY(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("Same-cycle implication failed.");
`define TFR_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("Next-cycle implication failed.");
`else
`define TFR_ASSERT_IMPLY(name, clk, rst_n, pre, post)
`define TFR_ASSERT_NEXT(name, clk, rst_n, pre, post)
`endif

`endif

// ===== rtl/tfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Telemetry frame receiver package
// Constants, codes and types shared by the receiver modules.
// ----------------------------------------------------------------------------
package tfr_pkg;

    localparam int DEF_PACKET_BYTES = 16;
    localparam int DEF_RECORD_WORDS = 16;
    localparam int MAX_PACKETS      = 8;

    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 32;
    localparam int OP_W       = 2;
    localparam int IDX_W      = 4;
    localparam int BANK_W     = 2;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_DEPTH  = 3;
    localparam int OUT_PTR_W  = 2;
    localparam int OUT_CNT_W  = 2;

    localparam logic [BYTE_W-1:0] HEADER_BYTE  = 8'h55;
    localparam logic [BYTE_W-1:0] TRAILER_BYTE = 8'hFE;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_WORD   = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_RECEIVE = 2'd0,
        OP_READ    = 2'd1,
        OP_CLEAR   = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        MODE_PARSING   = 3'b001,
        MODE_STOP_OK   = 3'b010,
        MODE_STOP_FAIL = 3'b100
    } t_mode;

    typedef struct packed {
        logic                     kind;
        logic                     status;
        logic signed [WORD_W-1:0] word;
    } t_result;

    // Picks a storage bank that holds neither the record copy nor, when use_stg is set, the staged copy.
    function automatic logic [BANK_W-1:0] scratch_bank(
        input logic [BANK_W-1:0] rec,
        input logic [BANK_W-1:0] stg,
        input logic              use_stg
    );
        logic [BANK_W-1:0] busy;
        logic [BANK_W-1:0] pick;
        busy = use_stg ? stg : rec;
        if (rec != 2'd0 && busy != 2'd0) begin
            pick = 2'd0;
        end else if (rec != 2'd1 && busy != 2'd1) begin
            pick = 2'd1;
        end else begin
            pick = 2'd2;
        end
        return pick;
    endfunction

endpackage

// ===== rtl/tfr_out_fifo.sv =====
// ----------------------------------------------------------------------------
// Telemetry frame receiver result queue
// Three-entry register queue that decouples results from the output stall.
// ----------------------------------------------------------------------------
module tfr_out_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  tfr_pkg::t_result              i_push_item,
    input  logic                          i_pop,
    output tfr_pkg::t_result              o_item,
    output logic                          o_valid,
    output logic [tfr_pkg::OUT_CNT_W-1:0] o_count
);
    import tfr_pkg::*;

    t_result              r_buf [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_wr_ptr;
    logic [OUT_PTR_W-1:0] r_rd_ptr;
    logic [OUT_CNT_W-1:0] r_cnt;
    logic [OUT_PTR_W-1:0] n_wr_ptr;
    logic [OUT_PTR_W-1:0] n_rd_ptr;
    logic [OUT_CNT_W-1:0] n_cnt;
    logic                 w_pop;

    assign w_pop   = i_pop && (r_cnt != '0);
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_buf[r_rd_ptr];
    assign o_count = r_cnt;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

// ===== rtl/telemetry_frame_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// Telemetry frame receiver
// Deframes a byte stream into checksummed packets, stages their words and
// commits them to a word record at the end of each buffer.
//
//   Channel   Direction  Beat contents
//   s_*       in         operation, rx_byte, end_of_buffer, word_index
//   m_*       out        result_kind, parse_status, record_word
//
// One beat is accepted per cycle while fewer than three results wait in the
// output stage and the result queue together.
// A result passes the s1 stage register and the result queue; words are read
// from a banked word memory with a registered read and one write port.
// Record, staged and scratch copies live in three banks selected per word by
// bank pointers, so commit and clear need no copying of words.
// Reset needs no clearing pass: per-word valid flags make the record read zero.
// ----------------------------------------------------------------------------
`include "telemetry_frame_receiver_unit_macros.svh"

module telemetry_frame_receiver_unit #(
    parameter int PACKET_BYTES = tfr_pkg::DEF_PACKET_BYTES,
    parameter int RECORD_WORDS = tfr_pkg::DEF_RECORD_WORDS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // Fields from bit 0: rx_byte [7:0], word_index [11:8], zero fill.
    input  logic [tfr_pkg::IN_DATA_W-1:0]  s_tdata,
    // Fields from bit 0: operation [1:0].
    input  logic [tfr_pkg::OP_W-1:0]       s_tuser,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // Fields from bit 0: parse_status [0], record_word [32:1], zero fill.
    output logic [tfr_pkg::OUT_DATA_W-1:0] m_tdata,
    // Fields from bit 0: result_kind [0].
    output logic                           m_tuser
);
    import tfr_pkg::*;

    localparam int WPP          = (PACKET_BYTES - 4) / 4;
    localparam int POS_W        = $clog2(PACKET_BYTES);
    localparam int RW_AW        = (RECORD_WORDS > 1) ? $clog2(RECORD_WORDS) : 1;
    localparam int MEM_DEPTH    = 3 << RW_AW;
    localparam int MEM_AW       = BANK_W + RW_AW;
    localparam int SLOT_W       = BYTE_W + $clog2(WPP + 1) + 1;
    localparam int ASM_W        = 3 * BYTE_W;
    localparam int IDX_EXT_W    = 7;
    localparam int OUT_PAD_W    = OUT_DATA_W - WORD_W - 1;

    localparam logic [POS_W-1:0] POS_HEADER   = '0;
    localparam logic [POS_W-1:0] POS_INDEX    = POS_W'(1);
    localparam logic [POS_W-1:0] POS_DATA_END = POS_W'(2 + 4 * WPP);
    localparam logic [POS_W-1:0] POS_SUM      = POS_W'(PACKET_BYTES - 2);
    localparam logic [POS_W-1:0] POS_LAST     = POS_W'(PACKET_BYTES - 1);

    logic [OP_W-1:0]      w_op;
    logic [BYTE_W-1:0]    w_byte;
    logic [IDX_W-1:0]     w_idx;
    logic                 w_acc;
    logic                 w_rx;
    logic                 w_rd;
    logic                 w_clr;

    logic [POS_W-1:0]     r_pos;
    logic [POS_W-1:0]     n_pos;
    logic [BYTE_W-1:0]    r_sum;
    logic [BYTE_W-1:0]    n_sum;
    logic                 r_hdr_bad;
    logic                 n_hdr_bad;
    logic [BYTE_W-1:0]    r_pnum;
    logic [BYTE_W-1:0]    n_pnum;
    t_mode                r_mode;
    t_mode                n_mode;
    t_mode                w_mode_tb;
    logic [POS_W-1:0]     w_pos_tb;
    logic [ASM_W-1:0]     r_asm;
    logic [ASM_W-1:0]     n_asm;
    logic [SLOT_W-1:0]    r_slot;
    logic [SLOT_W-1:0]    n_slot;
    logic [1:0]           w_lane;
    logic                 w_wr_en;
    logic                 w_pass;
    logic                 w_commit;
    logic                 w_status;

    logic [RECORD_WORDS-1:0] r_pend;
    logic [RECORD_WORDS-1:0] n_pend;
    logic [RECORD_WORDS-1:0] r_marks;
    logic [RECORD_WORDS-1:0] n_marks;
    logic [RECORD_WORDS-1:0] r_valid;
    logic [RECORD_WORDS-1:0] n_valid;
    logic [BANK_W-1:0]       r_rec [RECORD_WORDS];
    logic [BANK_W-1:0]       n_rec [RECORD_WORDS];
    logic [BANK_W-1:0]       r_stg [RECORD_WORDS];
    logic [BANK_W-1:0]       n_stg [RECORD_WORDS];
    logic [BANK_W-1:0]       w_scr [RECORD_WORDS];

    logic [WORD_W-1:0]    r_mem [MEM_DEPTH];
    logic [WORD_W-1:0]    r_rd_data;
    logic [RW_AW-1:0]     w_wr_slot;
    logic [BANK_W-1:0]    w_wr_bank;
    logic [MEM_AW-1:0]    w_wr_addr;
    logic [WORD_W-1:0]    w_wr_word;
    logic [IDX_EXT_W-1:0] w_idx_ext;
    logic [RW_AW-1:0]     w_rd_slot;
    logic                 w_rd_in;
    logic [MEM_AW-1:0]    w_rd_addr;

    logic                 r_s1_vld;
    logic                 r_s1_kind;
    logic                 r_s1_status;
    logic                 r_s1_ok;
    t_result              w_push_item;
    t_result              w_out_item;
    logic [OUT_CNT_W-1:0] w_fifo_cnt;
    logic [2:0]           w_inflight;

    assign w_op   = s_tuser;
    assign w_byte = s_tdata[7:0];
    assign w_idx  = s_tdata[11:8];
    assign w_acc  = s_tvalid && s_tready;
    assign w_rx   = w_acc && (w_op == OP_RECEIVE);
    assign w_rd   = w_acc && (w_op == OP_READ);
    assign w_clr  = w_acc && (w_op == OP_CLEAR);

    assign w_inflight = 3'(w_fifo_cnt) + 3'(r_s1_vld);
    assign s_tready   = (w_inflight <= 3'(OUT_DEPTH - 1));

    assign w_lane    = r_pos[1:0] - 2'd2;
    assign w_pos_tb  = (r_pos == POS_LAST) ? '0 : r_pos + 1'b1;
    assign w_wr_slot = r_slot[RW_AW-1:0];
    assign w_wr_bank = w_scr[w_wr_slot];
    assign w_wr_addr = {w_wr_bank, w_wr_slot};
    assign w_wr_word = {w_byte, r_asm};

    assign w_idx_ext = IDX_EXT_W'(w_idx);
    assign w_rd_slot = w_idx_ext[RW_AW-1:0];
    assign w_rd_in   = (w_idx_ext < IDX_EXT_W'(RECORD_WORDS));
    assign w_rd_addr = {r_rec[w_rd_slot], w_rd_slot};

    assign w_commit = w_rx && s_tlast && (w_pos_tb == '0);
    assign w_status = ((w_pos_tb != '0) || (w_mode_tb == MODE_STOP_FAIL)) ?
                      STATUS_FAIL : STATUS_OK;

    always_comb begin
        for (int i = 0; i < RECORD_WORDS; i++) begin
            w_scr[i] = scratch_bank(r_rec[i], r_stg[i], r_marks[i]);
        end
    end

    always_comb begin
        n_pos     = r_pos;
        n_sum     = r_sum;
        n_hdr_bad = r_hdr_bad;
        n_pnum    = r_pnum;
        w_mode_tb = r_mode;
        n_asm     = r_asm;
        n_slot    = r_slot;
        n_pend    = r_pend;
        w_wr_en   = 1'b0;
        w_pass    = 1'b0;
        if (w_rx) begin
            if (r_mode == MODE_PARSING) begin
                if (r_pos == POS_HEADER) begin
                    n_hdr_bad = (w_byte != HEADER_BYTE);
                end else if (r_pos == POS_INDEX) begin
                    n_pnum = w_byte;
                    n_slot = SLOT_W'(w_byte * WPP);
                end else if (r_pos < POS_DATA_END) begin
                    case (w_lane)
                        2'd0: n_asm = ASM_W'(w_byte);
                        2'd1: n_asm[15:8] = w_byte;
                        2'd2: n_asm[23:16] = w_byte;
                        2'd3: begin
                            w_wr_en = (r_slot < SLOT_W'(RECORD_WORDS));
                            n_slot  = r_slot + 1'b1;
                        end
                    endcase
                end else if (r_pos == POS_SUM) begin
                    if (w_byte != r_sum) begin
                        n_hdr_bad = 1'b1;
                    end
                end else if (r_pos == POS_LAST) begin
                    if (r_hdr_bad || (w_byte != TRAILER_BYTE)) begin
                        w_mode_tb = MODE_STOP_FAIL;
                    end else if (r_pnum >= BYTE_W'(MAX_PACKETS)) begin
                        w_mode_tb = MODE_STOP_OK;
                    end else begin
                        w_pass = 1'b1;
                    end
                end
                if (r_pos < POS_SUM) begin
                    n_sum = r_sum + w_byte;
                end
            end
            n_pos = w_pos_tb;
            if (r_pos == POS_LAST) begin
                n_sum     = '0;
                n_hdr_bad = 1'b0;
                n_pend    = '0;
            end
            if (w_wr_en) begin
                n_pend[w_wr_slot] = 1'b1;
            end
            if (s_tlast) begin
                n_pos     = '0;
                n_sum     = '0;
                n_hdr_bad = 1'b0;
                n_pnum    = '0;
                n_pend    = '0;
            end
        end
        n_mode = (w_rx && s_tlast) ? MODE_PARSING : w_mode_tb;
    end

    always_comb begin
        n_marks = r_marks;
        n_valid = r_valid;
        n_rec   = r_rec;
        n_stg   = r_stg;
        for (int i = 0; i < RECORD_WORDS; i++) begin
            if (w_pass && r_pend[i]) begin
                n_marks[i] = 1'b1;
                n_stg[i]   = w_scr[i];
            end
        end
        if (w_commit) begin
            for (int i = 0; i < RECORD_WORDS; i++) begin
                if (n_marks[i]) begin
                    n_rec[i]   = n_stg[i];
                    n_valid[i] = 1'b1;
                end
            end
        end
        if (w_rx && s_tlast) begin
            n_marks = '0;
        end
        if (w_clr) begin
            n_valid = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_sum     <= '0;
            r_hdr_bad <= 1'b0;
            r_pnum    <= '0;
            r_mode    <= MODE_PARSING;
            r_pend    <= '0;
            r_marks   <= '0;
            r_valid   <= '0;
            for (int i = 0; i < RECORD_WORDS; i++) begin
                r_rec[i] <= '0;
                r_stg[i] <= '0;
            end
            r_s1_vld  <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_sum     <= n_sum;
            r_hdr_bad <= n_hdr_bad;
            r_pnum    <= n_pnum;
            r_mode    <= n_mode;
            r_pend    <= n_pend;
            r_marks   <= n_marks;
            r_valid   <= n_valid;
            r_rec     <= n_rec;
            r_stg     <= n_stg;
            r_s1_vld  <= (w_rx && s_tlast) || w_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_asm  <= n_asm;
        r_slot <= n_slot;
        if (w_rx) begin
            r_s1_kind   <= KIND_STATUS;
            r_s1_status <= w_status;
            r_s1_ok     <= 1'b0;
        end else if (w_rd) begin
            r_s1_kind   <= KIND_WORD;
            r_s1_status <= STATUS_OK;
            r_s1_ok     <= w_rd_in && r_valid[w_rd_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_word;
        end
        if (w_rd) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    assign w_push_item.kind   = r_s1_kind;
    assign w_push_item.status = r_s1_status;
    assign w_push_item.word   = r_s1_ok ? r_rd_data : '0;

    tfr_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_s1_vld),
        .i_push_item (w_push_item),
        .i_pop       (m_tready),
        .o_item      (w_out_item),
        .o_valid     (m_tvalid),
        .o_count     (w_fifo_cnt)
    );

    assign m_tdata = {{OUT_PAD_W{1'b0}}, w_out_item.word, w_out_item.status};
    assign m_tuser = w_out_item.kind;

    `TFR_ASSERT_IMPLY(a_queue_room, i_clk, i_rst_n, r_s1_vld, w_fifo_cnt != OUT_CNT_W'(OUT_DEPTH))
    `TFR_ASSERT_IMPLY(a_record_bank_safe, i_clk, i_rst_n, w_wr_en, w_wr_bank != r_rec[w_wr_slot])
    `TFR_ASSERT_NEXT(a_status_follows_end, i_clk, i_rst_n, w_rx && s_tlast, r_s1_vld)
    `TFR_ASSERT_NEXT(a_marks_clear_at_end, i_clk, i_rst_n, w_rx && s_tlast, r_marks == '0)

endmodule
